// File: hw/rtl/ray_box_nearest_hit_assert.svh
// assertion macros for the ray box nearest hit block
// expects clk_i and rst_ni in the scope that uses them
`ifndef RAY_BOX_NEAREST_HIT_ASSERT_SVH
`define RAY_BOX_NEAREST_HIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define RBNH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define RBNH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rbnh_pkg.sv
// shared types and constants for the ray box nearest hit block
// no dependencies
`default_nettype none

package rbnh_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REACH = 3'd6;

  typedef struct packed {
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [31:0] box_center_z;
    logic [30:0]        box_half_x;
    logic [30:0]        box_half_y;
    logic [30:0]        box_half_z;
    logic               last_box;
  } box_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
  } hit_t;

endpackage

`default_nettype wire

// File: hw/rtl/rbnh_box_if.sv
// valid/ready channel carrying one box item
// depends on rbnh_pkg
`default_nettype none

interface rbnh_box_if;
  logic          valid;
  logic          ready;
  rbnh_pkg::box_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rbnh_hit_if.sv
// valid/ready channel carrying one hit result item
// depends on rbnh_pkg
`default_nettype none

interface rbnh_hit_if;
  logic          valid;
  logic          ready;
  rbnh_pkg::hit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rbnh_div.sv
// bit-serial restoring unsigned divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module rbnh_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shl;
  logic [DEN_W+1:0] trial;

  assign shl   = {rem_q, quo_q[NUM_W-1]};
  assign trial = {1'b0, shl} - {2'b00, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DEN_W+1]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = shl[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/ray_box_nearest_hit.sv
// nearest axis-aligned box hit by a ray, slab method, signed fixed point
// depends on rbnh_pkg, rbnh_box_if, rbnh_hit_if, rbnh_div, ray_box_nearest_hit_assert.svh
//
//   port     | dir | handshake     | content
//   box_i    | in  | valid/ready   | box center, half sizes, last flag
//   hit_o    | out | valid/ready   | hit flag and nearest distance
//   cfg_*_i  | in  | write enable  | ray origin, direction, max reach
//
// one box at a time; a box runs both slab divisions on each axis that is not flat,
// while a flat axis needs only a containment test and an early miss ends the box at once
// the first box of a ray also computes the direction
// length (bit-serial square root) and the three unit divisions
// all divisions share the bit-serial divider (one quotient bit per cycle)
// the result register lets the next box enter while a result waits;
// a last box stalls at the end only while the previous result is untaken
`default_nettype none

module ray_box_nearest_hit #(
  parameter int unsigned FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rbnh_box_if.sink                            box_i,
  rbnh_hit_if.source                          hit_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rbnh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rbnh_pkg::CFG_W-1:0]     cfg_wdata_i
);

  // divider numerator holds a 33-bit slab magnitude shifted by the fraction
  localparam int unsigned NUM_W = 33 + FRAC_BITS;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned TW    = NUM_W + 1;   // signed slab distance
  localparam int unsigned UW    = FRAC_BITS + 2; // signed unit component
  localparam int unsigned EPS_Q = ((1 << FRAC_BITS) + 5000) / 10000;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_UGO   = 4'd4;
  localparam logic [3:0] S_UWAIT = 4'd5;
  localparam logic [3:0] S_AXIS  = 4'd6;
  localparam logic [3:0] S_LGO   = 4'd7;
  localparam logic [3:0] S_LWAIT = 4'd8;
  localparam logic [3:0] S_HGO   = 4'd9;
  localparam logic [3:0] S_HWAIT = 4'd10;
  localparam logic [3:0] S_MERGE = 4'd11;
  localparam logic [3:0] S_CHECK = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  // configuration registers
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] reach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q   <= '{default: '0};
      dir_q   <= '{default: '0};
      reach_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbnh_pkg::REG_ORIGIN_X:  org_q[0] <= cfg_wdata_i;
        rbnh_pkg::REG_ORIGIN_Y:  org_q[1] <= cfg_wdata_i;
        rbnh_pkg::REG_ORIGIN_Z:  org_q[2] <= cfg_wdata_i;
        rbnh_pkg::REG_DIR_X:     dir_q[0] <= cfg_wdata_i;
        rbnh_pkg::REG_DIR_Y:     dir_q[1] <= cfg_wdata_i;
        rbnh_pkg::REG_DIR_Z:     dir_q[2] <= cfg_wdata_i;
        rbnh_pkg::REG_MAX_REACH: reach_q  <= cfg_wdata_i;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // state
  logic [3:0]          state_q, state_d;
  logic [1:0]          ax_q, ax_d;
  rbnh_pkg::box_t      box_q, box_d;
  logic [63:0]         prod_q, prod_d;
  logic [63:0]         sum_q, sum_d;
  logic [63:0]         n_q, n_d;
  logic [63:0]         r_q, r_d;
  logic [63:0]         b_q, b_d;
  logic signed [UW-1:0] unit_q [3];
  logic signed [UW-1:0] unit_d [3];
  logic [30:0]         nearest_q, nearest_d;
  logic                found_q, found_d;
  logic                prep_q, prep_d;
  logic                degen_q, degen_d;
  logic                box_hit_q, box_hit_d;
  logic signed [TW-1:0] tmin_q, tmin_d;
  logic signed [TW-1:0] tmax_q, tmax_d;
  logic signed [TW-1:0] e_q, e_d;
  logic signed [TW-1:0] x_q, x_d;
  logic                out_valid_q, out_valid_d;
  rbnh_pkg::hit_t      out_q, out_d;

  // divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  rbnh_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // per-axis operand selection
  logic signed [31:0]  dir_sel;
  logic signed [31:0]  org_sel;
  logic signed [31:0]  ctr_sel;
  logic [30:0]         half_sel;
  logic signed [UW-1:0] unit_sel;

  always_comb begin
    unique case (ax_q)
      2'd1: begin
        dir_sel  = dir_q[1];
        org_sel  = org_q[1];
        ctr_sel  = box_q.box_center_y;
        half_sel = box_q.box_half_y;
        unit_sel = unit_q[1];
      end
      2'd2: begin
        dir_sel  = dir_q[2];
        org_sel  = org_q[2];
        ctr_sel  = box_q.box_center_z;
        half_sel = box_q.box_half_z;
        unit_sel = unit_q[2];
      end
      default: begin
        dir_sel  = dir_q[0];
        org_sel  = org_q[0];
        ctr_sel  = box_q.box_center_x;
        half_sel = box_q.box_half_x;
        unit_sel = unit_q[0];
      end
    endcase
  end

  // direction magnitude, 2^31 included
  logic [31:0] dir_mag;
  assign dir_mag = dir_sel[31] ? (~dir_sel + 32'd1) : dir_sel;

  // slab bounds relative to the origin, 34-bit signed
  logic signed [33:0] c34, h34, o34, dlo, dhi;
  logic [32:0]        dlo_mag, dhi_mag;
  logic               outside;
  assign c34     = {{2{ctr_sel[31]}}, ctr_sel};
  assign h34     = {3'b000, half_sel};
  assign o34     = {{2{org_sel[31]}}, org_sel};
  assign dlo     = c34 - h34 - o34;
  assign dhi     = c34 + h34 - o34;
  assign dlo_mag = dlo[33] ? 33'(-dlo) : dlo[32:0];
  assign dhi_mag = dhi[33] ? 33'(-dhi) : dhi[32:0];
  assign outside = (o34 < c34 - h34) || (o34 > c34 + h34);

  logic [UW-2:0] u_mag;
  logic          flat;
  assign u_mag = unit_sel[UW-1] ? (UW-1)'(-unit_sel) : unit_sel[UW-2:0];
  assign flat  = ({1'b0, u_mag} <= UW'(EPS_Q));

  // signed divider result for slab divisions
  logic               slab_neg_lo, slab_neg_hi;
  logic signed [TW-1:0] quo_s;
  assign slab_neg_lo = dlo[33] != unit_sel[UW-1];
  assign slab_neg_hi = dhi[33] != unit_sel[UW-1];
  assign quo_s = {1'b0, div_quo};

  // reach clamped at zero, the starting limit of a ray
  logic [30:0] reach_clamp;
  assign reach_clamp = reach_q[31] ? 31'd0 : reach_q[30:0];

  // isqrt step
  logic [63:0] rb_sum;
  assign rb_sum = r_q + b_q;

  // slab merge
  logic signed [TW-1:0] near_t, far_t, tmin_m, tmax_m;
  assign near_t = (e_q > x_q) ? x_q : e_q;
  assign far_t  = (e_q > x_q) ? e_q : x_q;
  assign tmin_m = (near_t > tmin_q) ? near_t : tmin_q;
  assign tmax_m = (far_t < tmax_q) ? far_t : tmax_q;

  logic               found_new;
  logic [30:0]        nearest_new;
  assign found_new   = found_q | box_hit_q;
  assign nearest_new = box_hit_q ? tmin_q[30:0] : nearest_q;

  logic signed [TW-1:0] limit_t;
  assign limit_t = {{(TW-31){1'b0}}, nearest_q};

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    box_d       = box_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    n_d         = n_q;
    r_d         = r_q;
    b_d         = b_q;
    unit_d      = unit_q;
    nearest_d   = nearest_q;
    found_d     = found_q;
    prep_d      = prep_q;
    degen_d     = degen_q;
    box_hit_d   = box_hit_q;
    tmin_d      = tmin_q;
    tmax_d      = tmax_q;
    e_d         = e_q;
    x_d         = x_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_start   = 1'b0;
    div_num     = {dlo_mag, {FRAC_BITS{1'b0}}};
    div_den     = {{(DEN_W-UW+1){1'b0}}, u_mag};

    if (hit_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (box_i.valid) begin
          box_d     = box_i.data;
          box_hit_d = 1'b0;
          ax_d      = 2'd0;
          tmin_d    = '0;
          tmax_d    = limit_t;
          if (!prep_q) begin
            prod_d  = '0;
            sum_d   = '0;
            state_d = S_SQ;
          end else if (degen_q) begin
            state_d = S_FIN;
          end else begin
            state_d = S_AXIS;
          end
        end
      end
      // squares of the direction, one product per cycle, summed behind
      S_SQ: begin
        sum_d  = sum_q + prod_q;
        prod_d = dir_mag * dir_mag;
        if (ax_q == 2'd3) begin
          n_d     = sum_q + prod_q;
          r_d     = '0;
          b_d     = 64'd1 << 62;
          ax_d    = 2'd0;
          state_d = S_SQRT;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      // one root bit per cycle
      S_SQRT: begin
        if (n_q >= rb_sum) begin
          n_d = n_q - rb_sum;
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d = b_q >> 2;
        if (b_q == 64'd1) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        ax_d = 2'd0;
        if (r_q <= 64'(EPS_Q)) begin
          // short direction: ray never hits
          degen_d   = 1'b1;
          unit_d    = '{default: '0};
          nearest_d = reach_clamp;
          found_d   = 1'b0;
          prep_d    = 1'b1;
          state_d   = S_FIN;
        end else begin
          degen_d = 1'b0;
          state_d = S_UGO;
        end
      end
      S_UGO: begin
        div_start = 1'b1;
        div_num   = {1'b0, dir_mag, {FRAC_BITS{1'b0}}};
        div_den   = r_q[31:0];
        state_d   = S_UWAIT;
      end
      S_UWAIT: begin
        if (div_done) begin
          unit_d[ax_q] = dir_sel[31] ? -{1'b0, div_quo[UW-2:0]}
                                     : {1'b0, div_quo[UW-2:0]};
          if (ax_q == 2'd2) begin
            nearest_d = reach_clamp;
            found_d   = 1'b0;
            prep_d    = 1'b1;
            tmin_d    = '0;
            tmax_d    = {{(TW-31){1'b0}}, reach_clamp};
            ax_d      = 2'd0;
            state_d   = S_AXIS;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_UGO;
          end
        end
      end
      S_AXIS: begin
        if (flat) begin
          // flat axis: containment test only
          if (outside) begin
            state_d = S_FIN;
          end else if (ax_q == 2'd2) begin
            state_d = S_CHECK;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end else begin
          state_d = S_LGO;
        end
      end
      S_LGO: begin
        div_start = 1'b1;
        state_d   = S_LWAIT;
      end
      S_LWAIT: begin
        if (div_done) begin
          e_d     = slab_neg_lo ? -quo_s : quo_s;
          state_d = S_HGO;
        end
      end
      S_HGO: begin
        div_start = 1'b1;
        div_num   = {dhi_mag, {FRAC_BITS{1'b0}}};
        state_d   = S_HWAIT;
      end
      S_HWAIT: begin
        if (div_done) begin
          x_d     = slab_neg_hi ? -quo_s : quo_s;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        tmin_d = tmin_m;
        tmax_d = tmax_m;
        if (tmin_m > tmax_m) begin
          state_d = S_FIN;
        end else if (ax_q == 2'd2) begin
          state_d = S_CHECK;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_AXIS;
        end
      end
      // tmin never drops below zero, so it is the hit distance
      S_CHECK: begin
        box_hit_d = !(tmax_q < 0 || tmin_q > limit_t);
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!box_q.last_box) begin
          nearest_d = nearest_new;
          found_d   = found_new;
          state_d   = S_IDLE;
        end else if (!out_valid_q || hit_o.ready) begin
          nearest_d         = nearest_new;
          found_d           = found_new;
          out_valid_d       = 1'b1;
          out_d.hit         = found_new && !degen_q;
          out_d.hit_distance = (found_new && !degen_q) ? nearest_new : 31'd0;
          prep_d            = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      unit_q      <= '{default: '0};
      nearest_q   <= '0;
      found_q     <= 1'b0;
      prep_q      <= 1'b0;
      degen_q     <= 1'b0;
      box_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      unit_q      <= unit_d;
      nearest_q   <= nearest_d;
      found_q     <= found_d;
      prep_q      <= prep_d;
      degen_q     <= degen_d;
      box_hit_q   <= box_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q  <= box_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    n_q    <= n_d;
    r_q    <= r_d;
    b_q    <= b_d;
    tmin_q <= tmin_d;
    tmax_q <= tmax_d;
    e_q    <= e_d;
    x_q    <= x_d;
    out_q  <= out_d;
  end

  assign box_i.ready = (state_q == S_IDLE);
  assign hit_o.valid = out_valid_q;
  assign hit_o.data  = out_q;

  `include "ray_box_nearest_hit_assert.svh"

  // the divider is never restarted mid-division
  `RBNH_ASSERT_IMP(a_div_idle_start, div_start, !div_busy, "divider started while busy")
  // the running nearest distance only shrinks within one ray
  `RBNH_ASSERT_IMP(a_nearest_shrinks, prep_q && $past(prep_q), nearest_q <= $past(nearest_q),
    "nearest distance grew within a ray")
  // a box reaching the final check has a non-empty slab interval
  `RBNH_ASSERT_IMP(a_slab_order, state_q == S_CHECK, tmin_q <= tmax_q && tmin_q >= 0,
    "slab interval empty at final check")

endmodule

`default_nettype wire
